FILE: hdl/cartridge_bank_irq_mapper_defines.svh
// ----------------------------------------------------------------------------
// Cartridge bank and IRQ mapper: assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_IRQ_MAPPER_DEFINES_SVH
`define CARTRIDGE_BANK_IRQ_MAPPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define CBIM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("cbim assertion failed");

// Next-cycle implication, disabled while reset is low
`define CBIM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("cbim assertion failed");

`endif

FILE: hdl/cbim_pkg.sv
// ----------------------------------------------------------------------------
// Cartridge bank and IRQ mapper: package
// Codes, offsets, state and result types shared by the mapper modules.
// ----------------------------------------------------------------------------
package cbim_pkg;

	// Item operation
	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_TICK  = 1'b1
	} cbim_op_t;

	// Kind of mapping command in a result
	typedef enum logic [1:0] {
		MAP_NONE   = 2'd0,
		MAP_CHR    = 2'd1,
		MAP_PRG    = 2'd2,
		MAP_MIRROR = 2'd3
	} cbim_kind_t;

	// Register offsets after masking
	localparam logic [3:0] OFF_CHR_FIRST = 4'h0;
	localparam logic [3:0] OFF_CHR_LAST  = 4'h7;
	localparam logic [3:0] OFF_PRG       = 4'h8;
	localparam logic [3:0] OFF_MIRROR    = 4'h9;
	localparam logic [3:0] OFF_IRQ_CTRL  = 4'hA;
	localparam logic [3:0] OFF_LOW_BYTE  = 4'hB;
	localparam logic [3:0] OFF_HIGH_BYTE = 4'hC;
	localparam logic [3:0] OFF_IGNORED   = 4'hD;

	// Window and decode constants
	localparam logic [15:0] ALT_SHIFT     = 16'h2000;
	localparam logic [2:0]  WINDOW_TOP    = 3'b011;
	localparam logic [15:0] IRQ_FIRE_CNT  = 16'hFFFE;
	localparam logic [3:0]  PRG_MASK      = 4'hF;
	localparam logic [1:0]  MIRROR_MASK   = 2'h3;

	// Configuration register address
	localparam logic [1:0]  REG_ALT_ADDR  = 2'd0;

	// IRQ counter state
	typedef struct packed {
		logic [15:0] counter;
		logic [15:0] latch;
		logic        enabled;
		logic        ack;
		logic        asserted;
	} cbim_state_t;

	// One result beat
	typedef struct packed {
		cbim_kind_t  kind;
		logic [2:0]  slot;
		logic [7:0]  value;
		logic        irq;
		logic        unhandled;
	} cbim_result_t;

endpackage

FILE: hdl/cbim_in_if.sv
// ----------------------------------------------------------------------------
// Cartridge bank and IRQ mapper: input channel
// Valid/ready channel carrying one CPU write or clock tick per beat.
// ----------------------------------------------------------------------------
interface cbim_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [15:0] address;
	logic [7:0]  write_data;

	modport source (output valid, opcode, address, write_data, input ready);
	modport sink   (input valid, opcode, address, write_data, output ready);
endinterface

FILE: hdl/cbim_out_if.sv
// ----------------------------------------------------------------------------
// Cartridge bank and IRQ mapper: result channel
// Valid/ready channel carrying one mapping result per beat.
// ----------------------------------------------------------------------------
interface cbim_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  map_kind;
	logic [2:0]  map_slot;
	logic [7:0]  map_value;
	logic        irq_line;
	logic        unhandled_write;

	modport source (output valid, map_kind, map_slot, map_value, irq_line, unhandled_write,
		input ready);
	modport sink   (input valid, map_kind, map_slot, map_value, irq_line, unhandled_write,
		output ready);
endinterface

FILE: hdl/cartridge_bank_irq_mapper.sv
// ----------------------------------------------------------------------------
// Cartridge bank and IRQ mapper: top level
// Input register, single-pass decode with state update, registered result.
// ----------------------------------------------------------------------------
// An accepted item waits in s1; its decoded result is then offered from the output register.
// Throughput: one item per cycle while the result is not stalled; the state registers close the loop in one pass.
// A stalled result holds in the output register while one more item waits in s1.
// Reset (arst_n low, asynchronous): counter, latch, enable, acknowledge, IRQ line
// and the variant register clear; both pipeline stages empty.
`include "cartridge_bank_irq_mapper_defines.svh"

module cartridge_bank_irq_mapper
	import cbim_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	cbim_in_if.sink     in_ch,
	cbim_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic         alt_q;
	cbim_state_t  state_q;
	cbim_state_t  state_nxt;
	cbim_result_t res_nxt;
	cbim_result_t res_s2;
	logic         valid_s1;
	logic         opcode_s1;
	logic [15:0]  address_s1;
	logic [7:0]   data_s1;
	logic         valid_s2;
	logic         s2_free;
	logic         proc_s1;
	logic         in_beat;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = {31'd0, alt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == REG_ALT_ADDR) begin
			alt_q <= pwdata[0];
		end
	end

	// Handshake
	assign s2_free     = !valid_s2 || out_ch.ready;
	assign proc_s1     = valid_s1 && s2_free;
	assign in_ch.ready = !valid_s1 || s2_free;
	assign in_beat     = in_ch.valid && in_ch.ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (proc_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			opcode_s1  <= in_ch.opcode;
			address_s1 <= in_ch.address;
			data_s1    <= in_ch.write_data;
		end
	end

	cbim_decode u_decode (
		.alt        (alt_q),
		.opcode     (opcode_s1),
		.address    (address_s1),
		.write_data (data_s1),
		.cur        (state_q),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	// Advance the mapper state once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (proc_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (proc_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_ch.valid           = valid_s2;
	assign out_ch.map_kind        = res_s2.kind;
	assign out_ch.map_slot        = res_s2.slot;
	assign out_ch.map_value       = res_s2.value;
	assign out_ch.irq_line        = res_s2.irq;
	assign out_ch.unhandled_write = res_s2.unhandled;

	// The IRQ line rises only on a processed tick
	`CBIM_ASSERT_NXT(a_irq_rise_on_tick, clk, arst_n, !state_q.asserted && !(proc_s1 && opcode_s1 == OP_TICK), !state_q.asserted)
	// A firing tick asserts the line and drops the enable
	`CBIM_ASSERT_NXT(a_fire_clears_enable, clk, arst_n, proc_s1 && opcode_s1 == OP_TICK && state_q.enabled && state_q.counter == IRQ_FIRE_CNT, state_q.asserted && !state_q.enabled)
	// A held item stays in the input register
	`CBIM_ASSERT_NXT(a_s1_holds, clk, arst_n, valid_s1 && !s2_free, valid_s1 && $stable(address_s1) && $stable(opcode_s1))

endmodule

FILE: hdl/cbim_decode.sv
// ----------------------------------------------------------------------------
// Cartridge bank and IRQ mapper: item decoder
// Decodes one write or tick against the current state; gives next state and result.
// ----------------------------------------------------------------------------
module cbim_decode
	import cbim_pkg::*;
(
	input  logic         alt,
	input  logic         opcode,
	input  logic [15:0]  address,
	input  logic [7:0]   write_data,
	input  cbim_state_t  cur,
	output cbim_state_t  nxt,
	output cbim_result_t res
);

	always_comb begin
		logic        in_window;
		logic [15:0] shifted;
		logic [3:0]  off;
		nxt     = cur;
		res     = '0;
		res.kind = MAP_NONE;
		in_window = 1'b0;
		shifted = address;
		off     = address[3:0];

		if (cbim_op_t'(opcode) == OP_TICK) begin
			// Acknowledge drops the line before the counter step
			if (cur.ack) begin
				nxt.asserted = 1'b0;
				nxt.ack      = 1'b0;
			end
			if (cur.enabled) begin
				if (cur.counter == IRQ_FIRE_CNT) begin
					nxt.asserted = 1'b1;
					nxt.enabled  = 1'b0;
				end else begin
					nxt.counter = cur.counter - 16'd1;
				end
			end
		end else begin
			// Window check, then in alt mode shift the high window down
			if (alt) begin
				in_window = address[15];
				shifted   = address - ALT_SHIFT;
			end else begin
				in_window = (address[15:13] == WINDOW_TOP);
			end
			off = shifted[3:0];

			if (in_window) begin
				if (shifted[15:13] != WINDOW_TOP) begin
					res.unhandled = 1'b1;
				end else begin
					unique case (off) inside
						[OFF_CHR_FIRST:OFF_CHR_LAST]: begin
							res.kind  = MAP_CHR;
							res.slot  = off[2:0];
							res.value = write_data;
						end
						OFF_PRG: begin
							res.kind  = MAP_PRG;
							res.value = {4'd0, write_data[3:0] & PRG_MASK};
						end
						OFF_MIRROR: begin
							res.kind  = MAP_MIRROR;
							res.value = {6'd0, write_data[1:0] & MIRROR_MASK};
						end
						OFF_IRQ_CTRL: begin
							nxt.enabled = write_data[0];
							nxt.ack     = 1'b1;
							if (alt) begin
								nxt.counter = cur.latch;
							end
						end
						OFF_LOW_BYTE: begin
							if (alt) begin
								nxt.latch[7:0] = write_data;
							end else begin
								nxt.counter[7:0] = write_data;
							end
						end
						OFF_HIGH_BYTE: begin
							if (alt) begin
								nxt.latch[15:8] = write_data;
							end else begin
								nxt.counter[15:8] = write_data;
							end
						end
						OFF_IGNORED: begin
						end
						default: begin
							res.unhandled = 1'b1;
						end
					endcase
				end
			end
		end

		// Line level after this step
		res.irq = nxt.asserted;
	end

endmodule
